// ===== design/si_pkg.sv =====
package si_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int MID_DEPTH   = 4;
	localparam int OUT_DEPTH   = 2;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_PROPER = 2'd1,
		ST_TOUCH  = 2'd2
	} status_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

endpackage

// ===== design/si_fifo.sv =====
module si_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = si_pkg::MID_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   wdata,
	input  logic               pop,
	output logic [WIDTH-1:0]   rdata,
	output si_pkg::q_flags_t   flags
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign flags.full  = (cnt_q == CW'(DEPTH));
	assign flags.empty = (cnt_q == '0);
	assign do_push     = push && !flags.full;
	assign do_pop      = pop && !flags.empty;
	assign rdata       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== design/si_front.sv =====
module si_front #(
	parameter int W = si_pkg::COORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [W-1:0]    ax,
	input  logic signed [W-1:0]    ay,
	input  logic signed [W-1:0]    bx,
	input  logic signed [W-1:0]    by,
	input  logic signed [W-1:0]    cx,
	input  logic signed [W-1:0]    cy,
	input  logic signed [W-1:0]    dx,
	input  logic signed [W-1:0]    dy,
	output logic                   out_valid,
	input  si_pkg::q_flags_t       out_flags,
	output si_pkg::status_t        status,
	output logic signed [W-1:0]    ep_x,
	output logic signed [W-1:0]    ep_y,
	output logic signed [2*W+2:0]  s1,
	output logic signed [2*W+2:0]  s2,
	output logic signed [W-1:0]    c_x,
	output logic signed [W-1:0]    c_y,
	output logic signed [W-1:0]    d_x,
	output logic signed [W-1:0]    d_y
);

	localparam int DWD = W + 1;
	localparam int PW  = 2 * W + 2;
	localparam int SW  = 2 * W + 3;

	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
	} pt_t;

	typedef struct packed {
		logic signed [DWD-1:0] x;
		logic signed [DWD-1:0] y;
	} dv_t;

	function automatic dv_t dsub(input pt_t p, input pt_t q);
		dv_t r;
		r.x = DWD'(p.x) - DWD'(q.x);
		r.y = DWD'(p.y) - DWD'(q.y);
		return r;
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	pt_t a_in, b_in, c_in, d_in;
	pt_t a_s1, b_s1, c_s1, d_s1;
	pt_t a_s2, b_s2, c_s2, d_s2;
	pt_t a_s3, b_s3, c_s3, d_s3;
	dv_t ab_s1, ac_s1, ad_s1, cd_s1, ca_s1, cb_s1, da_s1, db_s1, bc_s1, bd_s1;

	logic signed [PW-1:0] po_s2 [8];
	logic signed [PW-1:0] pd_s2 [8];
	logic signed [SW-1:0] or_s3 [4];
	logic signed [SW-1:0] dt_s3 [4];

	logic [3:0]      zr;
	logic [3:0]      ng;
	logic [3:0]      touch;
	logic            prop;
	si_pkg::status_t st_nx;
	pt_t             ep_nx;

	si_pkg::status_t      status_s4;
	pt_t                  ep_s4;
	logic signed [SW-1:0] s1_s4, s2_s4;
	pt_t                  c_s4, d_s4;

	assign a_in = '{x: ax, y: ay};
	assign b_in = '{x: bx, y: by};
	assign c_in = '{x: cx, y: cy};
	assign d_in = '{x: dx, y: dy};

	assign adv       = !v_s4 || !out_flags.full;
	assign in_ready  = adv;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1  <= a_in;
			b_s1  <= b_in;
			c_s1  <= c_in;
			d_s1  <= d_in;
			ab_s1 <= dsub(b_in, a_in);
			ac_s1 <= dsub(c_in, a_in);
			ad_s1 <= dsub(d_in, a_in);
			cd_s1 <= dsub(d_in, c_in);
			ca_s1 <= dsub(a_in, c_in);
			cb_s1 <= dsub(b_in, c_in);
			da_s1 <= dsub(a_in, d_in);
			db_s1 <= dsub(b_in, d_in);
			bc_s1 <= dsub(c_in, b_in);
			bd_s1 <= dsub(d_in, b_in);

			a_s2     <= a_s1;
			b_s2     <= b_s1;
			c_s2     <= c_s1;
			d_s2     <= d_s1;
			po_s2[0] <= ab_s1.x * ac_s1.y;
			po_s2[1] <= ac_s1.x * ab_s1.y;
			po_s2[2] <= ab_s1.x * ad_s1.y;
			po_s2[3] <= ad_s1.x * ab_s1.y;
			po_s2[4] <= cd_s1.x * ca_s1.y;
			po_s2[5] <= ca_s1.x * cd_s1.y;
			po_s2[6] <= cd_s1.x * cb_s1.y;
			po_s2[7] <= cb_s1.x * cd_s1.y;
			pd_s2[0] <= ca_s1.x * cb_s1.x;
			pd_s2[1] <= ca_s1.y * cb_s1.y;
			pd_s2[2] <= da_s1.x * db_s1.x;
			pd_s2[3] <= da_s1.y * db_s1.y;
			pd_s2[4] <= ac_s1.x * ad_s1.x;
			pd_s2[5] <= ac_s1.y * ad_s1.y;
			pd_s2[6] <= bc_s1.x * bd_s1.x;
			pd_s2[7] <= bc_s1.y * bd_s1.y;

			a_s3 <= a_s2;
			b_s3 <= b_s2;
			c_s3 <= c_s2;
			d_s3 <= d_s2;
			for (int k = 0; k < 4; k++) begin
				or_s3[k] <= SW'(po_s2[2*k]) - SW'(po_s2[2*k+1]);
				dt_s3[k] <= SW'(pd_s2[2*k]) + SW'(pd_s2[2*k+1]);
			end

			status_s4 <= st_nx;
			ep_s4     <= ep_nx;
			s1_s4     <= or_s3[0];
			s2_s4     <= or_s3[1];
			c_s4      <= c_s3;
			d_s4      <= d_s3;
		end
	end

	// orientation order: C and D against AB, then A and B against CD
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			zr[k]    = (or_s3[k] == '0);
			ng[k]    = or_s3[k][SW-1];
			touch[k] = zr[k] && (dt_s3[k][SW-1] || (dt_s3[k] == '0));
		end
		prop = !zr[0] && !zr[1] && (ng[0] ^ ng[1]) && !zr[2] && !zr[3] && (ng[2] ^ ng[3]);
	end

	always_comb begin
		st_nx = si_pkg::ST_NONE;
		ep_nx = '0;
		priority if (prop) begin
			st_nx = si_pkg::ST_PROPER;
		end else if (touch[0]) begin
			st_nx = si_pkg::ST_TOUCH;
			ep_nx = c_s3;
		end else if (touch[1]) begin
			st_nx = si_pkg::ST_TOUCH;
			ep_nx = d_s3;
		end else if (touch[2]) begin
			st_nx = si_pkg::ST_TOUCH;
			ep_nx = a_s3;
		end else if (touch[3]) begin
			st_nx = si_pkg::ST_TOUCH;
			ep_nx = b_s3;
		end else begin
			st_nx = si_pkg::ST_NONE;
		end
	end

	assign status = status_s4;
	assign ep_x   = ep_s4.x;
	assign ep_y   = ep_s4.y;
	assign s1     = s1_s4;
	assign s2     = s2_s4;
	assign c_x    = c_s4.x;
	assign c_y    = c_s4.y;
	assign d_x    = d_s4.x;
	assign d_y    = d_s4.y;

endmodule

// ===== design/si_back.sv =====
module si_back #(
	parameter int W = si_pkg::COORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  si_pkg::q_flags_t       in_flags,
	output logic                   in_pop,
	input  si_pkg::status_t        status,
	input  logic signed [W-1:0]    ep_x,
	input  logic signed [W-1:0]    ep_y,
	input  logic signed [2*W+2:0]  s1,
	input  logic signed [2*W+2:0]  s2,
	input  logic signed [W-1:0]    c_x,
	input  logic signed [W-1:0]    c_y,
	input  logic signed [W-1:0]    d_x,
	input  logic signed [W-1:0]    d_y,
	output logic                   out_valid,
	input  si_pkg::q_flags_t       out_flags,
	output si_pkg::status_t        out_status,
	output logic signed [W-1:0]    out_px,
	output logic signed [W-1:0]    out_py
);

	localparam int SW  = 2 * W + 3;
	localparam int DW  = 2 * W + 4;
	localparam int K   = W + 2;
	localparam int HW  = 2 * W + 1;
	localparam int LW  = 2 * W + 3;
	localparam int HD  = 2 * W + 2;
	localparam int LD  = 2 * W + 4;
	localparam int NW  = 3 * W + 2;
	localparam int NST = W + 5;

	logic           adv;
	logic [NST-1:0] vld_s;

	si_pkg::status_t      status_s1, status_s2, status_s3;
	logic signed [W-1:0]  epx_s1, epy_s1, epx_s2, epy_s2, epx_s3, epy_s3;
	logic signed [DW-1:0] den_s1, den_s2, den_s3;
	logic signed [HW-1:0] pch_x_s1, pdh_x_s1, pch_y_s1, pdh_y_s1;
	logic signed [LW-1:0] pcl_x_s1, pdl_x_s1, pcl_y_s1, pdl_y_s1;
	logic signed [HD-1:0] hi_x_s2, hi_y_s2;
	logic signed [LD-1:0] lo_x_s2, lo_y_s2;
	logic signed [NW-1:0] nx_s3, ny_s3;

	si_pkg::status_t     status_s [W+1];
	logic signed [W-1:0] epx_s [W+1];
	logic signed [W-1:0] epy_s [W+1];
	logic [NW-1:0]       rx_s [W+1];
	logic [NW-1:0]       ry_s [W+1];
	logic [DW-1:0]       dd_s [W+1];
	logic [W-1:0]        qx_s [W+1];
	logic [W-1:0]        qy_s [W+1];
	logic                negx_s [W+1];
	logic                negy_s [W+1];

	si_pkg::status_t     status_slast;
	logic signed [W-1:0] px_slast, py_slast;
	logic [W-1:0]        qsx, qsy;

	assign adv       = !vld_s[NST-1] || !out_flags.full;
	assign in_pop    = adv && !in_flags.empty;
	assign out_valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], !in_flags.empty};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1 <= status;
			epx_s1    <= ep_x;
			epy_s1    <= ep_y;
			den_s1    <= DW'(s2) - DW'(s1);
			pch_x_s1  <= c_x * $signed(s2[SW-1:K]);
			pdh_x_s1  <= d_x * $signed(s1[SW-1:K]);
			pch_y_s1  <= c_y * $signed(s2[SW-1:K]);
			pdh_y_s1  <= d_y * $signed(s1[SW-1:K]);
			pcl_x_s1  <= c_x * $signed({1'b0, s2[K-1:0]});
			pdl_x_s1  <= d_x * $signed({1'b0, s1[K-1:0]});
			pcl_y_s1  <= c_y * $signed({1'b0, s2[K-1:0]});
			pdl_y_s1  <= d_y * $signed({1'b0, s1[K-1:0]});

			status_s2 <= status_s1;
			epx_s2    <= epx_s1;
			epy_s2    <= epy_s1;
			den_s2    <= den_s1;
			hi_x_s2   <= HD'(pch_x_s1) - HD'(pdh_x_s1);
			hi_y_s2   <= HD'(pch_y_s1) - HD'(pdh_y_s1);
			lo_x_s2   <= LD'(pcl_x_s1) - LD'(pdl_x_s1);
			lo_y_s2   <= LD'(pcl_y_s1) - LD'(pdl_y_s1);

			status_s3 <= status_s2;
			epx_s3    <= epx_s2;
			epy_s3    <= epy_s2;
			den_s3    <= den_s2;
			nx_s3     <= $signed({hi_x_s2[2*W-1:0], {K{1'b0}}}) + NW'(lo_x_s2);
			ny_s3     <= $signed({hi_y_s2[2*W-1:0], {K{1'b0}}}) + NW'(lo_y_s2);

			status_s[0] <= status_s3;
			epx_s[0]    <= epx_s3;
			epy_s[0]    <= epy_s3;
			rx_s[0]     <= nx_s3[NW-1] ? NW'(-nx_s3) : NW'(nx_s3);
			ry_s[0]     <= ny_s3[NW-1] ? NW'(-ny_s3) : NW'(ny_s3);
			dd_s[0]     <= den_s3[DW-1] ? DW'(-den_s3) : DW'(den_s3);
			qx_s[0]     <= '0;
			qy_s[0]     <= '0;
			negx_s[0]   <= nx_s3[NW-1] ^ den_s3[DW-1];
			negy_s[0]   <= ny_s3[NW-1] ^ den_s3[DW-1];
		end
	end

	// restoring division, one quotient bit per stage, most significant first
	for (genvar j = 1; j <= W; j++) begin : g_div
		localparam int I = W - j;
		logic [NW:0]  tx, ty;
		logic [W-1:0] qxn, qyn;

		always_comb begin
			tx       = {1'b0, rx_s[j-1]} - ((NW+1)'(dd_s[j-1]) << I);
			ty       = {1'b0, ry_s[j-1]} - ((NW+1)'(dd_s[j-1]) << I);
			qxn      = qx_s[j-1];
			qyn      = qy_s[j-1];
			qxn[I]   = !tx[NW];
			qyn[I]   = !ty[NW];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				status_s[j] <= status_s[j-1];
				epx_s[j]    <= epx_s[j-1];
				epy_s[j]    <= epy_s[j-1];
				rx_s[j]     <= tx[NW] ? rx_s[j-1] : tx[NW-1:0];
				ry_s[j]     <= ty[NW] ? ry_s[j-1] : ty[NW-1:0];
				dd_s[j]     <= dd_s[j-1];
				qx_s[j]     <= qxn;
				qy_s[j]     <= qyn;
				negx_s[j]   <= negx_s[j-1];
				negy_s[j]   <= negy_s[j-1];
			end
		end
	end

	assign qsx = negx_s[W] ? -qx_s[W] : qx_s[W];
	assign qsy = negy_s[W] ? -qy_s[W] : qy_s[W];

	always_ff @(posedge clk) begin
		if (adv) begin
			status_slast <= status_s[W];
			px_slast     <= (status_s[W] == si_pkg::ST_PROPER) ? $signed(qsx) : epx_s[W];
			py_slast     <= (status_s[W] == si_pkg::ST_PROPER) ? $signed(qsy) : epy_s[W];
		end
	end

	assign out_status = status_slast;
	assign out_px     = px_slast;
	assign out_py     = py_slast;

endmodule

// ===== design/segment_intersection.sv =====
// Throughput: one transaction per cycle while full stays low (queue back-pressure stalls
// it); the COORD_WIDTH-stage restoring divider produces one quotient bit per stage.
// Reset (arst_n low): pipeline valid bits and queue pointers clear; the block
// comes up empty and not full. Datapath registers are not reset.
module segment_intersection #(
	parameter int COORD_WIDTH = si_pkg::COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	input  logic signed [COORD_WIDTH-1:0] dx,
	input  logic signed [COORD_WIDTH-1:0] dy,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    status,
	output logic signed [COORD_WIDTH-1:0] px,
	output logic signed [COORD_WIDTH-1:0] py
);

	localparam int W  = COORD_WIDTH;
	localparam int SW = 2 * W + 3;

	typedef struct packed {
		si_pkg::status_t      status;
		logic signed [W-1:0]  ep_x;
		logic signed [W-1:0]  ep_y;
		logic signed [SW-1:0] s1;
		logic signed [SW-1:0] s2;
		logic signed [W-1:0]  c_x;
		logic signed [W-1:0]  c_y;
		logic signed [W-1:0]  d_x;
		logic signed [W-1:0]  d_y;
	} mid_t;

	typedef struct packed {
		si_pkg::status_t     status;
		logic signed [W-1:0] px;
		logic signed [W-1:0] py;
	} res_t;

	mid_t             mid_wr, mid_rd;
	res_t             res_wr, res_rd;
	si_pkg::q_flags_t mid_flags, out_flags;
	logic             front_ready, front_valid;
	logic             back_pop, back_valid;

	si_front #(
		.W(W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push),
		.in_ready (front_ready),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by       (by),
		.cx       (cx),
		.cy       (cy),
		.dx       (dx),
		.dy       (dy),
		.out_valid(front_valid),
		.out_flags(mid_flags),
		.status   (mid_wr.status),
		.ep_x     (mid_wr.ep_x),
		.ep_y     (mid_wr.ep_y),
		.s1       (mid_wr.s1),
		.s2       (mid_wr.s2),
		.c_x      (mid_wr.c_x),
		.c_y      (mid_wr.c_y),
		.d_x      (mid_wr.d_x),
		.d_y      (mid_wr.d_y)
	);

	si_fifo #(
		.WIDTH($bits(mid_t)),
		.DEPTH(si_pkg::MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (front_valid),
		.wdata (mid_wr),
		.pop   (back_pop),
		.rdata (mid_rd),
		.flags (mid_flags)
	);

	si_back #(
		.W(W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_flags  (mid_flags),
		.in_pop    (back_pop),
		.status    (mid_rd.status),
		.ep_x      (mid_rd.ep_x),
		.ep_y      (mid_rd.ep_y),
		.s1        (mid_rd.s1),
		.s2        (mid_rd.s2),
		.c_x       (mid_rd.c_x),
		.c_y       (mid_rd.c_y),
		.d_x       (mid_rd.d_x),
		.d_y       (mid_rd.d_y),
		.out_valid (back_valid),
		.out_flags (out_flags),
		.out_status(res_wr.status),
		.out_px    (res_wr.px),
		.out_py    (res_wr.py)
	);

	si_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(si_pkg::OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (back_valid),
		.wdata (res_wr),
		.pop   (pop),
		.rdata (res_rd),
		.flags (out_flags)
	);

	assign full   = !front_ready;
	assign empty  = out_flags.empty;
	assign status = res_rd.status;
	assign px     = res_rd.px;
	assign py     = res_rd.py;

	a_full_only_on_mid_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mid_flags.full)
		else $error("input blocked while the middle queue has room");

	a_back_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		back_valid && out_flags.full |=> back_valid)
		else $error("back end dropped a stalled transaction");

	a_none_is_origin: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (status == si_pkg::ST_NONE) |-> (px == '0) && (py == '0))
		else $error("no-intersection result with a nonzero point");

endmodule
